// ----- design/djs_pkg.sv -----
// ----------------------------------------------------------------------------
// Deadline job sequencer package
// Shared sizes, controller states and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package djs_pkg;

  // Job store depth. One slot per stored job at most.
  localparam int MAX_JOBS = 16;

  // Field widths of the transaction payloads.
  localparam int ID_W     = 8;
  localparam int PROFIT_W = 16;
  localparam int DL_W     = 8;
  localparam int SUM_W    = 20;
  localparam int SLOT_W   = 5;

  // Store index and job count widths.
  localparam int IDX_W = $clog2(MAX_JOBS);
  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  // Controller states.
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETUP,
    ST_PLACE,
    ST_EMIT
  } djs_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic setup;
    logic place;
    logic emit;
  } djs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic place_done;
    logic emit_last;
    logic out_free;
  } djs_status_t;

endpackage

// ----- design/deadline_job_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// Deadline job sequencer
// Greedy job sequencing with deadlines over a set of up to 16 jobs.
// ----------------------------------------------------------------------------
// Usage:
// Jobs enter on the input channel (in_valid_i / in_stall_o), one transaction
// per cycle while in_stall_o is low, and are kept sorted by profit as they
// arrive. The transaction with last_job_i set closes the set; jobs past the
// 16th are dropped, but a dropped job's last flag still closes the set.
// After the closing transaction the input channel stalls through setup,
// placement and result emission; placement handles one job per cycle in a
// single slot search unit. Results then leave on the output channel
// (out_valid_o / out_stall_i) at one per cycle while out_stall_i is low, one
// per filled slot in ascending slot order; the last carries the total profit.
// A set that fills no slot gives one result with slot_filled_o low.
// The output register holds its transaction while out_stall_i is high; the
// input channel reopens once the last result is in that register.
// Reset clears the job count, slot occupancy and the output valid.
// ----------------------------------------------------------------------------
module deadline_job_sequencer_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [djs_pkg::ID_W-1:0]        job_id_i,
  input  logic [djs_pkg::PROFIT_W-1:0]    profit_i,
  input  logic [djs_pkg::DL_W-1:0]        deadline_i,
  input  logic                           last_job_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [djs_pkg::SLOT_W-1:0]      slot_number_o,
  output logic [djs_pkg::ID_W-1:0]        scheduled_id_o,
  output logic                           slot_filled_o,
  output logic [djs_pkg::SUM_W-1:0]       total_profit_o,
  output logic                           last_result_o
);
  import djs_pkg::*;

  djs_cmd_t    cmd;
  djs_status_t status;

  // Sequencing control.
  djs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_job_i (last_job_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Job store, slot placement and output register.
  djs_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .job_id_i       (job_id_i),
    .profit_i       (profit_i),
    .deadline_i     (deadline_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .slot_number_o  (slot_number_o),
    .scheduled_id_o (scheduled_id_o),
    .slot_filled_o  (slot_filled_o),
    .total_profit_o (total_profit_o),
    .last_result_o  (last_result_o)
  );

endmodule

// ----- design/djs_ctrl.sv -----
// ----------------------------------------------------------------------------
// Deadline job sequencer controller
// Steps through loading, setup, slot placement and result emission, and
// issues at most one datapath command per cycle.
// ----------------------------------------------------------------------------
module djs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                last_job_i,
  output logic                in_stall_o,
  input  djs_pkg::djs_status_t status_i,
  output djs_pkg::djs_cmd_t    cmd_o
);
  import djs_pkg::*;

  djs_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (last_job_i) begin
            state_d = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_PLACE;
      end
      ST_PLACE: begin
        if (status_i.place_done) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.place = 1'b1;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.emit_last) begin
            state_d = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

// ----- design/djs_datapath.sv -----
// ----------------------------------------------------------------------------
// Deadline job sequencer datapath
// Keeps the jobs sorted by profit as they arrive, places them into slots one
// job per cycle and drives the output register.
// ----------------------------------------------------------------------------
module djs_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  djs_pkg::djs_cmd_t                     cmd_i,
  output djs_pkg::djs_status_t                  status_o,
  input  logic [djs_pkg::ID_W-1:0]              job_id_i,
  input  logic [djs_pkg::PROFIT_W-1:0]          profit_i,
  input  logic [djs_pkg::DL_W-1:0]              deadline_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic [djs_pkg::SLOT_W-1:0]            slot_number_o,
  output logic [djs_pkg::ID_W-1:0]              scheduled_id_o,
  output logic                                 slot_filled_o,
  output logic [djs_pkg::SUM_W-1:0]             total_profit_o,
  output logic                                 last_result_o
);
  import djs_pkg::*;

  // Sorted job store, highest profit at entry 0.
  logic [ID_W-1:0]     s_id_q   [MAX_JOBS];
  logic [PROFIT_W-1:0] s_prof_q [MAX_JOBS];
  logic [DL_W-1:0]     s_dl_q   [MAX_JOBS];

  logic [CNT_W-1:0]    count_q;
  logic [DL_W-1:0]     maxd_q;
  logic [CNT_W-1:0]    horizon_q;
  logic [MAX_JOBS-1:0] used_q;
  logic [ID_W-1:0]     slot_job_q [MAX_JOBS];
  logic [SUM_W-1:0]    sum_q;

  logic                out_valid_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [ID_W-1:0]     out_id_q;
  logic                out_filled_q;
  logic [SUM_W-1:0]    out_total_q;
  logic                out_last_q;

  logic                store_ok;
  logic [MAX_JOBS-1:0] ins;
  logic [MAX_JOBS-1:0] take_prev;
  logic [CNT_W-1:0]    horizon_d;
  logic [CNT_W-1:0]    dl_clamp;
  logic [MAX_JOBS:0]   low_mask;
  logic [MAX_JOBS-1:0] free_mask;
  logic                hit;
  logic [IDX_W-1:0]    hit_idx;
  logic [SUM_W:0]      sum_wide;
  logic [SUM_W-1:0]    sum_d;
  logic                any_used;
  logic [IDX_W-1:0]    low_idx;
  logic                emit_last;

  assign store_ok = count_q < CNT_W'(MAX_JOBS);

  // Insert position: the new job goes after every stored job of equal or
  // higher profit, which keeps arrival order among equal profits.
  always_comb begin
    ins       = '0;
    take_prev = '0;
    for (int k = 0; k < MAX_JOBS; k++) begin
      ins[k] = !((CNT_W'(k) < count_q) && (s_prof_q[k] >= profit_i));
    end
    for (int k = 1; k < MAX_JOBS; k++) begin
      take_prev[k] = ins[k-1];
    end
  end

  // Sorted store: insert on load, shift toward entry 0 while placing.
  // Entry 0 has no predecessor and can only take the new job.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && store_ok) begin
      if (ins[0]) begin
        s_id_q[0]   <= job_id_i;
        s_prof_q[0] <= profit_i;
        s_dl_q[0]   <= deadline_i;
      end
      for (int k = 1; k < MAX_JOBS; k++) begin
        if (ins[k]) begin
          if (take_prev[k]) begin
            s_id_q[k]   <= s_id_q[k-1];
            s_prof_q[k] <= s_prof_q[k-1];
            s_dl_q[k]   <= s_dl_q[k-1];
          end else begin
            s_id_q[k]   <= job_id_i;
            s_prof_q[k] <= profit_i;
            s_dl_q[k]   <= deadline_i;
          end
        end
      end
    end else if (cmd_i.place) begin
      for (int k = 0; k < MAX_JOBS - 1; k++) begin
        s_id_q[k]   <= s_id_q[k+1];
        s_prof_q[k] <= s_prof_q[k+1];
        s_dl_q[k]   <= s_dl_q[k+1];
      end
    end
  end

  // Horizon is the smaller of the job count and the largest deadline.
  assign horizon_d = ({{(DL_W-CNT_W){1'b0}}, count_q} < maxd_q) ? count_q
                                                                 : maxd_q[CNT_W-1:0];

  // Latest free slot at or before the clamped deadline of the head job.
  // Slot t (from 1) lives in bit t-1.
  always_comb begin
    dl_clamp  = (s_dl_q[0] > {{(DL_W-CNT_W){1'b0}}, horizon_q}) ? horizon_q
                                                               : s_dl_q[0][CNT_W-1:0];
    low_mask  = ((MAX_JOBS+1)'(1) << dl_clamp) - (MAX_JOBS+1)'(1);
    free_mask = ~used_q & low_mask[MAX_JOBS-1:0];
    hit       = |free_mask;
    hit_idx   = '0;
    for (int t = 0; t < MAX_JOBS; t++) begin
      if (free_mask[t]) begin
        hit_idx = IDX_W'(t);
      end
    end
  end

  // Saturating profit accumulation.
  always_comb begin
    sum_wide = {1'b0, sum_q} + (SUM_W+1)'(s_prof_q[0]);
    sum_d    = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
  end

  // Lowest filled slot goes out next; it is the last one when no other
  // filled slot remains.
  always_comb begin
    any_used  = |used_q;
    emit_last = (used_q & (used_q - MAX_JOBS'(1))) == '0;
    low_idx   = '0;
    for (int t = MAX_JOBS - 1; t >= 0; t--) begin
      if (used_q[t]) begin
        low_idx = IDX_W'(t);
      end
    end
  end

  // Control registers of the datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      maxd_q    <= '0;
      horizon_q <= '0;
      used_q    <= '0;
      sum_q     <= '0;
    end else begin
      if (cmd_i.load && store_ok) begin
        count_q <= count_q + CNT_W'(1);
        if (deadline_i > maxd_q) begin
          maxd_q <= deadline_i;
        end
      end
      if (cmd_i.setup) begin
        horizon_q <= horizon_d;
        maxd_q    <= '0;
        used_q    <= '0;
        sum_q     <= '0;
      end
      if (cmd_i.place) begin
        count_q <= count_q - CNT_W'(1);
        if (hit) begin
          used_q[hit_idx] <= 1'b1;
          sum_q           <= sum_d;
        end
      end
      if (cmd_i.emit) begin
        used_q[low_idx] <= 1'b0;
      end
    end
  end

  // Slot to job id table.
  always_ff @(posedge clk_i) begin
    if (cmd_i.place && hit) begin
      slot_job_q[hit_idx] <= s_id_q[0];
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload; an empty schedule gives a single unfilled result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_slot_q   <= any_used ? (SLOT_W'(low_idx) + SLOT_W'(1)) : '0;
      out_id_q     <= any_used ? slot_job_q[low_idx] : '0;
      out_filled_q <= any_used;
      out_total_q  <= emit_last ? sum_q : '0;
      out_last_q   <= emit_last;
    end
  end

  assign status_o.place_done = (count_q == '0);
  assign status_o.emit_last  = emit_last;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign slot_number_o  = out_slot_q;
  assign scheduled_id_o = out_id_q;
  assign slot_filled_o  = out_filled_q;
  assign total_profit_o = out_total_q;
  assign last_result_o  = out_last_q;

endmodule

// ----- design/djs_checker.sv -----
// ----------------------------------------------------------------------------
// Deadline job sequencer checker
// Port-level checks on the sequencer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module djs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        last_job_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [djs_pkg::SLOT_W-1:0]   slot_number_o,
  input logic [djs_pkg::ID_W-1:0]     scheduled_id_o,
  input logic                        slot_filled_o,
  input logic [djs_pkg::SUM_W-1:0]    total_profit_o,
  input logic                        last_result_o
);

  // A closing job transaction stops intake while the set is scheduled.
  a_close_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_job_i |=> in_stall_o)
    else $error("input not stalled after closing job");

  // An unfilled result is the sole, final result and names no slot.
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !slot_filled_o |->
      last_result_o && (slot_number_o == '0) && (total_profit_o == '0))
    else $error("malformed empty result");

  // Only the final result carries a total.
  a_total_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_result_o |-> (total_profit_o == '0))
    else $error("total profit on a non-final result");

  // A filled slot is counted from one.
  a_filled_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && slot_filled_o |-> (slot_number_o != '0))
    else $error("filled result with slot zero");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(slot_number_o) && $stable(scheduled_id_o))
    else $error("stalled result changed");

endmodule

bind deadline_job_sequencer_top djs_checker u_djs_checker (.*);

// ----- test/deadline_job_sequencer_top_test.sv -----
// ----------------------------------------------------------------------------
// Deadline job sequencer testbench
// Sends job sets over the input channel and checks every result against an
// in-bench greedy scheduler. Directed sets cover a single job, a job that can
// never be placed, equal profits and an overfull store. Random sets, a long
// receiver hold-off and a full-rate stretch follow.
// ----------------------------------------------------------------------------
module deadline_job_sequencer_top_test;
  import djs_pkg::*;

  localparam int LIMIT       = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  // One result transaction as seen on the output channel.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
    logic              filled;
    logic [SUM_W-1:0]  total;
    logic              last;
  } slot_entry_t;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [ID_W-1:0]     job_id_i     = '0;
  logic [PROFIT_W-1:0] profit_i     = '0;
  logic [DL_W-1:0]     deadline_i   = '0;
  logic                last_job_i   = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [SLOT_W-1:0]   slot_number_o;
  logic [ID_W-1:0]     scheduled_id_o;
  logic                slot_filled_o;
  logic [SUM_W-1:0]    total_profit_o;
  logic                last_result_o;

  // Job store of the bench scheduler.
  logic [ID_W-1:0]     held_id       [MAX_JOBS];
  logic [PROFIT_W-1:0] held_profit   [MAX_JOBS];
  logic [DL_W-1:0]     held_deadline [MAX_JOBS];
  int                  held_count = 0;

  // Results still awaited from the block, oldest first.
  slot_entry_t awaited_slots[$];

  int  cycle_count   = 0;
  int  jobs_sent     = 0;
  int  sets_closed   = 0;
  int  results_seen  = 0;
  int  mismatches    = 0;
  bit  tx_idle_en    = 1'b0;
  bit  rx_idle_en    = 1'b0;
  int  hold_reqs     = 0;
  int  holds_done    = 0;
  logic rx_hold      = 1'b0;
  int  rx_burst_left = 0;

  deadline_job_sequencer_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .job_id_i       (job_id_i),
    .profit_i       (profit_i),
    .deadline_i     (deadline_i),
    .last_job_i     (last_job_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .slot_number_o  (slot_number_o),
    .scheduled_id_o (scheduled_id_o),
    .slot_filled_o  (slot_filled_o),
    .total_profit_o (total_profit_o),
    .last_result_o  (last_result_o)
  );

  // Free-running clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Greedy schedule of the stored set; the expected results are queued.
  task automatic schedule_jobs();
    int          order [MAX_JOBS];
    bit          used  [MAX_JOBS+1];
    logic [ID_W-1:0] owner [MAX_JOBS+1];
    slot_entry_t res   [MAX_JOBS];
    int          n, i, j, t, d, maxd, horizon, k, sum;
    bit          placed;
    begin
      n = held_count;
      // Stable insertion sort, highest profit first.
      for (i = 0; i < n; i++) begin
        j = i;
        while (j > 0 && held_profit[order[j-1]] < held_profit[i]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
      end
      maxd = 0;
      for (i = 0; i < n; i++)
        if (held_deadline[i] > maxd) maxd = held_deadline[i];
      horizon = (n < maxd) ? n : maxd;
      for (t = 0; t <= MAX_JOBS; t++) used[t] = 1'b0;
      sum = 0;
      // Each job takes the latest free slot at or before its clamped deadline.
      for (i = 0; i < n; i++) begin
        d = held_deadline[order[i]];
        if (d > horizon) d = horizon;
        placed = 1'b0;
        for (t = d; t >= 1 && !placed; t--) begin
          if (!used[t]) begin
            used[t]  = 1'b1;
            owner[t] = held_id[order[i]];
            sum += held_profit[order[i]];
            if (sum > 20'hFFFFF) sum = 20'hFFFFF;
            placed = 1'b1;
          end
        end
      end
      k = 0;
      for (t = 1; t <= horizon; t++) begin
        if (used[t]) begin
          res[k] = '{slot: t[SLOT_W-1:0], id: owner[t], filled: 1'b1, total: '0, last: 1'b0};
          k++;
        end
      end
      if (k == 0) begin
        awaited_slots.push_back('{slot: '0, id: '0, filled: 1'b0, total: '0, last: 1'b1});
      end else begin
        res[k-1].total = sum[SUM_W-1:0];
        res[k-1].last  = 1'b1;
        for (i = 0; i < k; i++) awaited_slots.push_back(res[i]);
      end
      held_count = 0;
      sets_closed++;
    end
  endtask

  // Offers one job transaction and waits until the block accepts it.
  task automatic send_job(input logic [ID_W-1:0] id, input logic [PROFIT_W-1:0] profit,
                          input logic [DL_W-1:0] deadline, input logic last);
    int gap;
    begin
      gap = 0;
      if (tx_idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      job_id_i   <= id;
      profit_i   <= profit;
      deadline_i <= deadline;
      last_job_i <= last;
      @(posedge clk_i);
      while (in_stall_o !== 1'b0) @(posedge clk_i);
      // Accepted at this edge: update the bench job store.
      if (held_count < MAX_JOBS) begin
        held_id[held_count]       = id;
        held_profit[held_count]   = profit;
        held_deadline[held_count] = deadline;
        held_count++;
      end
      jobs_sent++;
      if (last) schedule_jobs();
    end
  endtask

  // Stops offering and waits until every awaited result has come out.
  task automatic wait_for_results();
    begin
      in_valid_i <= 1'b0;
      while (awaited_slots.size() != 0) @(posedge clk_i);
      repeat (MAX_JOBS + 4) @(posedge clk_i);
    end
  endtask

  task automatic report_mismatch(input string what, input slot_entry_t want,
                                 input slot_entry_t got);
    begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("Mismatch (%s) at cycle %0d: expected slot=%0d id=%0h filled=%0b total=%0d last=%0b, got slot=%0d id=%0h filled=%0b total=%0d last=%0b",
                 what, cycle_count, want.slot, want.id, want.filled, want.total, want.last,
                 got.slot, got.id, got.filled, got.total, got.last);
    end
  endtask

  // Result checker: every accepted result transaction meets the oldest expectation.
  always @(posedge clk_i) begin
    slot_entry_t got;
    slot_entry_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      got = '{slot: slot_number_o, id: scheduled_id_o, filled: slot_filled_o,
              total: total_profit_o, last: last_result_o};
      results_seen++;
      if (awaited_slots.size() == 0) begin
        report_mismatch("nothing expected", '0, got);
      end else begin
        want = awaited_slots.pop_front();
        if (got.slot !== want.slot || got.id !== want.id || got.filled !== want.filled ||
            got.total !== want.total || got.last !== want.last)
          report_mismatch("field", want, got);
      end
    end
  end

  // Receiver stall: random-length bursts, or a forced hold-off.
  always @(posedge clk_i) begin
    if (rx_hold) begin
      out_stall_i <= 1'b1;
    end else if (rx_idle_en && rx_burst_left > 0) begin
      out_stall_i <= 1'b1;
      rx_burst_left--;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      out_stall_i   <= 1'b1;
      rx_burst_left = $urandom_range(0, 15);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Long receiver hold-off, counted here once requested by a test.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_reqs != holds_done) begin
        holds_done++;
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               awaited_slots.size());
      $display("deadline_job_sequencer_top_test: FAIL");
      $finish;
    end
  end

  // A single job with the widest fields; its deadline clamps to a horizon of one.
  task automatic test_single_job();
    begin
      send_job(8'hFF, 16'hFFFF, 8'hFF, 1'b1);
      wait_for_results();
    end
  endtask

  // A job with deadline zero is never placed, so the set yields an empty result.
  task automatic test_unplaceable();
    begin
      send_job(8'h00, 16'h1234, 8'h00, 1'b1);
      wait_for_results();
    end
  endtask

  // Equal profits must keep arrival order; the zero-profit job is squeezed out.
  task automatic test_equal_profits();
    begin
      send_job(8'h00, 16'h0000, 8'h02, 1'b0);
      send_job(8'hA5, 16'h0007, 8'h01, 1'b0);
      send_job(8'h5A, 16'h0007, 8'h03, 1'b0);
      send_job(8'h3C, 16'h0007, 8'h03, 1'b1);
      wait_for_results();
    end
  endtask

  // Sixteen top-profit jobs fill every slot; the two extra jobs are dropped but
  // the last one still closes the set.
  task automatic test_store_overflow();
    int i;
    begin
      for (i = 0; i < MAX_JOBS + 2; i++)
        send_job(8'(MAX_JOBS - 1 - i), 16'hFFFF, (i < MAX_JOBS) ? 8'hFF : 8'h01,
                 i == MAX_JOBS + 1);
      wait_for_results();
    end
  endtask

  // Random job sets: mostly small, a few overfull, with varied idling.
  task automatic test_random_sets(input int job_goal);
    int n, i, style, r;
    logic [PROFIT_W-1:0] p;
    logic [DL_W-1:0]     d;
    begin
      while (jobs_sent < job_goal) begin
        n          = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 6);
        style      = $urandom_range(0, 2);
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
        for (i = 0; i < n; i++) begin
          case (style)
            0: p = PROFIT_W'($urandom);
            1: p = PROFIT_W'($urandom_range(0, 3));
            default: p = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
          endcase
          r = $urandom_range(0, 9);
          if (r == 0)      d = '0;
          else if (r == 1) d = DL_W'($urandom);
          else             d = DL_W'($urandom_range(1, n + 1));
          send_job(ID_W'($urandom), p, d, i == n - 1);
        end
        // Now and then the sender waits for the block to drain.
        if ($urandom_range(0, 7) == 0) wait_for_results();
      end
      wait_for_results();
    end
  endtask

  // The receiver holds off for a long stretch while sets keep coming.
  task automatic test_output_hold_off();
    int s, i;
    begin
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      hold_reqs++;
      for (s = 0; s < 3; s++)
        for (i = 0; i < 5; i++)
          send_job(ID_W'($urandom), PROFIT_W'($urandom), DL_W'($urandom_range(1, 6)), i == 4);
      wait_for_results();
    end
  endtask

  // Back-to-back sets with no idling on either side.
  task automatic test_full_rate(input int count);
    int sent, n, i;
    begin
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      sent = 0;
      while (sent < count) begin
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++)
          send_job(ID_W'($urandom), PROFIT_W'($urandom), DL_W'($urandom_range(0, n + 1)),
                   i == n - 1);
        sent += n;
      end
      wait_for_results();
    end
  endtask

  // Test sequence.
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_single_job();
    test_unplaceable();
    test_equal_profits();
    test_store_overflow();
    test_random_sets(320);
    test_output_hold_off();
    test_full_rate(60);
    if (awaited_slots.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived.", awaited_slots.size());
    end
    $display("Ran %0d job transactions in %0d sets and checked %0d results in %0d cycles.",
             jobs_sent, sets_closed, results_seen, cycle_count);
    $display("Covered ties, dropped and overflow jobs, empty sets, idling and a long hold-off.");
    if (mismatches == 0) begin
      $display("deadline_job_sequencer_top_test: PASS");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("deadline_job_sequencer_top_test: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/djs_pkg.sv
design/djs_ctrl.sv
design/djs_datapath.sv
design/deadline_job_sequencer_top.sv
design/djs_checker.sv
test/deadline_job_sequencer_top_test.sv
